>>> hdl/bde_pkg.sv
package bde_pkg;

  // Stream word widths, padded to whole bytes.
  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 72;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 19;

  localparam logic [CfgIdxW-1:0] CFG_TEMP_LIMIT     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CURRENT_LIMIT  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DRAIN_DIVISOR  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_RUNTIME_FACTOR = 2'd3;

  localparam logic signed [15:0] TEMP_LIMIT_RST     = 16'sd7680;
  localparam logic [18:0]        CURRENT_LIMIT_RST  = 19'd43520;
  localparam logic [15:0]        DRAIN_DIVISOR_RST  = 16'd4800;
  localparam logic [15:0]        RUNTIME_FACTOR_RST = 16'd2400;

  // Battery level in Q24 percent.
  localparam logic [30:0] LEVEL_MIN   = 31'd100663296;
  localparam logic [30:0] LEVEL_MAX   = 31'd1677721600;
  localparam logic [30:0] LEVEL_RESET = 31'd1577058304;

  // 0.92 in Q16.
  localparam logic [15:0] DERATE_Q16 = 16'd60293;

  localparam logic [16:0] HOURS_MIN = 17'd1024;
  localparam logic [16:0] HOURS_MAX = 17'd107520;
  localparam logic [18:0] CUR_FLOOR = 19'd256;
  localparam logic [12:0] MV_BASE   = 13'd3350;

  // Quotient bits produced by the serial divider for each division.
  localparam logic [4:0] DROP_STEPS  = 5'd31;
  localparam logic [4:0] HOURS_STEPS = 5'd17;

endpackage

>>> hdl/battery_drain_estimator.sv
// Per-tick battery drain estimator. Each input word carries one tick of
// sensor data; the block forms a supply-current estimate from a linear load
// model, derates it by 0.92 when the corridor temperature or the current is
// over its limit, drains the stored battery level by current over the drain
// divisor (held between 6 and 100 percent), and returns one output word with
// current, level, terminal voltage, runtime and the charging and derate
// flags. A new word is accepted only once the previous one is through;
// a saturating quotient skips its division, and the block stalls while the
// previous result still waits at the output. The one bit-serial divider,
// shared by the drain and runtime divisions, forms them in 31 and 17 steps.
// The input is ready only while the block is idle; a finished result waits
// in the output register without blocking the next input. Configuration is
// to be written only while the block is idle; the block does not enforce it.
module battery_drain_estimator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // duty[9:0], gasket_pressure[25:10], door_shut[26], quiet_period[27],
  // shelter_mode[28], corridor_temp[44:29], tick_count[76:45], zero pad
  input  logic [bde_pkg::InDataW-1:0]    s_axis_tdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // supply_current[18:0], battery_level[33:19], battery_millivolts[46:34],
  // runtime_hours[63:47], charging[64], heat_derate[65], zero pad
  output logic [bde_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_we_i,
  input  logic [bde_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [bde_pkg::CfgDataW-1:0]   cfg_data_i
);
  import bde_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DER  = 3'd1;
  localparam logic [2:0] S_LD1  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_LVL  = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_LD2  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0] state_q, state_d;

  logic signed [15:0] temp_limit_q;
  logic [18:0]        current_limit_q;
  logic [15:0]        drain_divisor_q;
  logic [15:0]        runtime_factor_q;

  logic [30:0] charge_q, charge_d;
  logic [18:0] cur_q, cur_d;
  logic        derate_q, derate_d;
  logic        charging_q, charging_d;
  logic        sat_q, sat_d;
  logic        phase_q, phase_d;

  // Shared serial divider: partial remainder, dividend/quotient shifter.
  logic [33:0] rem_q, rem_d;
  logic [46:0] num_q, num_d;
  logic [33:0] den_q, den_d;
  logic [4:0]  cnt_q, cnt_d;

  logic        out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  // Input fields.
  logic [9:0]         in_duty;
  logic [15:0]        in_gp;
  logic               in_door, in_quiet, in_shelter;
  logic signed [15:0] in_temp;
  logic [31:0]        in_tick;

  assign in_duty    = s_axis_tdata[9:0];
  assign in_gp      = s_axis_tdata[25:10];
  assign in_door    = s_axis_tdata[26];
  assign in_quiet   = s_axis_tdata[27];
  assign in_shelter = s_axis_tdata[28];
  assign in_temp    = $signed(s_axis_tdata[44:29]);
  assign in_tick    = s_axis_tdata[76:45];

  // Load model in 1/1024 mA, rounded half up to Q8.
  logic [20:0] load_sum;
  logic [18:0] load_cur;
  assign load_sum = 21'd16384 + 21'(in_duty) * 21'd125 + 21'(in_gp) * 21'd18
                  + (in_door ? 21'd8192 : 21'd2048)
                  + (in_quiet ? 21'd5120 : 21'd0)
                  + (in_shelter ? 21'd14336 : 21'd0);
  assign load_cur = 19'((load_sum + 21'd2) >> 2);

  // Shared multiplier.
  logic [30:0] mul_a;
  logic [15:0] mul_b;
  logic [46:0] mul_p;
  assign mul_a = (state_q == S_DER) ? {12'd0, cur_q} : charge_q;
  assign mul_b = (state_q == S_DER) ? DERATE_Q16 : runtime_factor_q;
  assign mul_p = 47'(mul_a) * 47'(mul_b);

  logic [34:0] derated;
  assign derated = mul_p[34:0] + 35'd32768;

  logic [15:0] div_eff;
  assign div_eff = (drain_divisor_q == 16'd0) ? 16'd1 : drain_divisor_q;

  // One restoring step.
  logic [35:0] trial;
  logic        take;
  assign trial = {1'b0, rem_q, num_q[46]} - {2'b00, den_q};
  assign take  = ~trial[35];

  logic [31:0] lvl_diff;
  assign lvl_diff = {1'b0, charge_q} - {1'b0, num_q[30:0]};

  logic [18:0] cur_floor;
  assign cur_floor = (cur_q > CUR_FLOOR) ? cur_q : CUR_FLOOR;

  logic [34:0] mv_sum;
  logic [12:0] mv;
  assign mv_sum = {charge_q, 3'b000} + 35'(charge_q) + 35'd8388608;
  assign mv     = MV_BASE + 13'(mv_sum[34:24]);

  logic [16:0] hours;
  always_comb begin
    if (sat_q || num_q[16:0] > HOURS_MAX) begin
      hours = HOURS_MAX;
    end else if (num_q[16:0] < HOURS_MIN) begin
      hours = HOURS_MIN;
    end else begin
      hours = num_q[16:0];
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_comb begin
    state_d     = state_q;
    charge_d    = charge_q;
    cur_d       = cur_q;
    derate_d    = derate_q;
    charging_d  = charging_q;
    sat_d       = sat_q;
    phase_d     = phase_q;
    rem_d       = rem_q;
    num_d       = num_q;
    den_d       = den_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cur_d      = load_cur;
          derate_d   = (in_temp > temp_limit_q) || (load_cur > current_limit_q);
          charging_d = (in_tick == 32'd0);
          state_d    = S_DER;
        end
      end
      S_DER: begin
        if (derate_q) begin
          cur_d = derated[34:16];
        end
        state_d = S_LD1;
      end
      S_LD1: begin
        // Drop = (cur << 16) / divisor; a quotient of 2^31 or more always
        // clamps the level, so only the low 31 quotient bits are formed.
        phase_d = 1'b0;
        den_d   = {18'd0, div_eff};
        rem_d   = {30'd0, cur_q[18:15]};
        num_d   = {cur_q[14:0], 32'd0};
        cnt_d   = DROP_STEPS;
        sat_d   = ({12'd0, cur_q[18:15]} >= div_eff);
        state_d = sat_d ? S_LVL : S_DIV;
      end
      S_DIV: begin
        rem_d = take ? trial[33:0] : {rem_q[32:0], num_q[46]};
        num_d = {num_q[45:0], take};
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          state_d = phase_q ? S_FIN : S_LVL;
        end
      end
      S_LVL: begin
        if (sat_q || lvl_diff[31] || lvl_diff[30:0] < LEVEL_MIN) begin
          charge_d = LEVEL_MIN;
        end else begin
          charge_d = lvl_diff[30:0];
        end
        state_d = S_MUL;
      end
      S_MUL: begin
        num_d   = mul_p;
        den_d   = 34'(cur_floor) * 34'd25600;
        state_d = S_LD2;
      end
      S_LD2: begin
        // Runtime quotients of 2^17 or more clamp to the maximum.
        phase_d = 1'b1;
        rem_d   = {4'd0, num_q[46:17]};
        num_d   = {num_q[16:0], 30'd0};
        cnt_d   = HOURS_STEPS;
        sat_d   = ({4'd0, num_q[46:17]} >= den_q);
        state_d = sat_d ? S_FIN : S_DIV;
      end
      S_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {6'd0, derate_q, charging_q, hours, mv,
                         charge_q[30:16], cur_q};
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      charge_q         <= LEVEL_RESET;
      out_valid_q      <= 1'b0;
      temp_limit_q     <= TEMP_LIMIT_RST;
      current_limit_q  <= CURRENT_LIMIT_RST;
      drain_divisor_q  <= DRAIN_DIVISOR_RST;
      runtime_factor_q <= RUNTIME_FACTOR_RST;
      phase_q          <= 1'b0;
      sat_q            <= 1'b0;
      cnt_q            <= 5'd0;
    end else begin
      state_q     <= state_d;
      charge_q    <= charge_d;
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
      sat_q       <= sat_d;
      cnt_q       <= cnt_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_TEMP_LIMIT:     temp_limit_q     <= $signed(cfg_data_i[15:0]);
          CFG_CURRENT_LIMIT:  current_limit_q  <= cfg_data_i;
          CFG_DRAIN_DIVISOR:  drain_divisor_q  <= cfg_data_i[15:0];
          CFG_RUNTIME_FACTOR: runtime_factor_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    derate_q   <= derate_d;
    charging_q <= charging_d;
    rem_q      <= rem_d;
    num_q      <= num_d;
    den_q      <= den_d;
    out_data_q <= out_data_d;
  end

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    charge_q >= LEVEL_MIN && charge_q <= LEVEL_MAX)
    else $error("battery level left its range");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < den_q)
    else $error("divider remainder not below divisor");

  a_hours_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_data_q[63:47] >= HOURS_MIN && out_data_q[63:47] <= HOURS_MAX)
    else $error("runtime hours out of range");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input still ready after accepting a word");

endmodule

>>> tb/sv/battery_drain_estimator_tb.sv
`timescale 1ns / 100ps

module battery_drain_estimator_tb;
  import bde_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int StallCycles   = 400;
  localparam int RandomTicks   = 150;

  localparam longint LvlFloor = LEVEL_MIN;
  localparam longint LvlCeil  = LEVEL_MAX;
  localparam longint HrsFloor = HOURS_MIN;
  localparam longint HrsCeil  = HOURS_MAX;
  localparam longint CurFloor = CUR_FLOOR;

  // Fields listed from the top bit down, so the packed value is the word layout.
  typedef struct packed {
    logic [31:0]        tick_count;
    logic signed [15:0] corridor_temp;
    logic               shelter_mode;
    logic               quiet_period;
    logic               door_shut;
    logic [15:0]        gasket_pressure;
    logic [9:0]         blower_duty;
  } tick_t;

  typedef struct packed {
    logic        heat_derate;
    logic        charging;
    logic [16:0] runtime_hours;
    logic [12:0] battery_millivolts;
    logic [14:0] battery_level;
    logic [18:0] supply_current;
  } report_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  // duty[9:0], gasket_pressure[25:10], door_shut[26], quiet_period[27],
  // shelter_mode[28], corridor_temp[44:29], tick_count[76:45], zero pad
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // supply_current[18:0], battery_level[33:19], battery_millivolts[46:34],
  // runtime_hours[63:47], charging[64], heat_derate[65], zero pad
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  battery_drain_estimator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Shadow copy of the block's registers and battery state.
  int          temp_limit_r   = TEMP_LIMIT_RST;
  logic [18:0] current_limit_r = CURRENT_LIMIT_RST;
  logic [15:0] drain_div_r     = DRAIN_DIVISOR_RST;
  logic [15:0] runtime_r       = RUNTIME_FACTOR_RST;
  longint      level_q24       = LEVEL_RESET;

  report_t pending_reports[$];
  int      tx_idle_pct = 0;
  int      rx_idle_pct = 0;
  int      stall_len = 0;
  bit      stall_toggle = 1'b0;
  int      ticks_sent = 0;
  int      reports_seen = 0;
  int      settings_written = 0;
  int      mismatches = 0;

  function automatic longint load_current(tick_t t);
    longint sum;
    sum = 16 * 1024 + 125 * longint'(t.blower_duty) + 18 * longint'(t.gasket_pressure);
    sum += t.door_shut ? 8 * 1024 : 2 * 1024;
    if (t.quiet_period) sum += 5 * 1024;
    if (t.shelter_mode) sum += 14 * 1024;
    return (sum + 2) >>> 2;
  endfunction

  // Advances the battery state by one tick and returns the report it produces.
  function automatic report_t drain_step(tick_t t);
    report_t r;
    longint  cur;
    longint  divisor;
    longint  lvl;
    longint  cur_floored;
    longint  hrs;
    cur = load_current(t);
    r.heat_derate = (int'(t.corridor_temp) > temp_limit_r) ||
                    (cur > longint'(current_limit_r));
    if (r.heat_derate) cur = (cur * longint'(DERATE_Q16) + 32768) >>> 16;
    cur = cur & 64'h7FFFF;
    divisor = (drain_div_r == 16'd0) ? 1 : longint'(drain_div_r);
    lvl = level_q24 - (cur << 16) / divisor;
    if (lvl < LvlFloor) lvl = LvlFloor;
    if (lvl > LvlCeil) lvl = LvlCeil;
    level_q24 = lvl;
    cur_floored = (cur > CurFloor) ? cur : CurFloor;
    hrs = (lvl * longint'(runtime_r)) / (25600 * cur_floored);
    if (hrs < HrsFloor) hrs = HrsFloor;
    if (hrs > HrsCeil) hrs = HrsCeil;
    r.supply_current     = 19'(cur);
    r.battery_level      = 15'(lvl >>> 16);
    r.battery_millivolts = 13'(longint'(MV_BASE) + ((9 * lvl + (longint'(1) << 23)) >>> 24));
    r.runtime_hours      = 17'(hrs);
    r.charging           = (t.tick_count == 32'd0);
    return r;
  endfunction

  function automatic tick_t make_tick(logic [9:0] duty, logic [15:0] gp, logic [2:0] flags,
                                      logic signed [15:0] temp, logic [31:0] tick);
    tick_t t;
    t.blower_duty     = duty;
    t.gasket_pressure = gp;
    {t.shelter_mode, t.quiet_period, t.door_shut} = flags;
    t.corridor_temp   = temp;
    t.tick_count      = tick;
    return t;
  endfunction

  function automatic tick_t random_tick();
    logic [31:0] tick;
    tick = ($urandom_range(7) == 0) ? 32'd0 : $urandom;
    return make_tick(10'($urandom), 16'($urandom), 3'($urandom), 16'($urandom), tick);
  endfunction

  // Leaves tvalid high after acceptance so back-to-back words need no toggle.
  // Each cycle before an offer the sender idles with the given percentage.
  task automatic send_tick(tick_t t);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW - $bits(tick_t)){1'b0}}, t};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_reports.push_back(drain_step(t));
    ticks_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_reports.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_regs(logic signed [15:0] temp_lim, logic [18:0] cur_lim,
                              logic [15:0] divisor, logic [15:0] runtime);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_TEMP_LIMIT;
    cfg_data_i  <= {{(CfgDataW - 16){1'b0}}, temp_lim};
    @(posedge clk_i);
    cfg_index_i <= CFG_CURRENT_LIMIT;
    cfg_data_i  <= cur_lim;
    @(posedge clk_i);
    cfg_index_i <= CFG_DRAIN_DIVISOR;
    cfg_data_i  <= {{(CfgDataW - 16){1'b0}}, divisor};
    @(posedge clk_i);
    cfg_index_i <= CFG_RUNTIME_FACTOR;
    cfg_data_i  <= {{(CfgDataW - 16){1'b0}}, runtime};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    temp_limit_r    = temp_lim;
    current_limit_r = cur_lim;
    drain_div_r     = divisor;
    runtime_r       = runtime;
    settings_written++;
  endtask

  task automatic check_field(string field, longint exp_v, longint got_v);
    if (exp_v != got_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, got_v);
    end
  endtask

  // Output side: random backpressure, long stalls on request, result checking.
  initial begin
    bit      stall_seen;
    int      stall_left;
    report_t got;
    report_t want;
    stall_seen = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(report_t)-1:0];
        reports_seen++;
        if (pending_reports.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word, expected none, actual %h", $time, got);
        end else begin
          want = pending_reports.pop_front();
          check_field("supply_current", want.supply_current, got.supply_current);
          check_field("battery_level", want.battery_level, got.battery_level);
          check_field("battery_millivolts", want.battery_millivolts, got.battery_millivolts);
          check_field("runtime_hours", want.runtime_hours, got.runtime_hours);
          check_field("charging", want.charging, got.charging);
          check_field("heat_derate", want.heat_derate, got.heat_derate);
        end
      end
      if (stall_toggle != stall_seen) begin
        stall_seen = stall_toggle;
        stall_left = stall_len;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no word moved for %0d cycles", $time, WatchdogLimit);
    $display("== FAIL ==");
    $finish;
  end

  // Reset register values: field extremes, each flag alone, and the temperature
  // limit itself versus one step above it.
  task automatic test_reset_values();
    send_tick(make_tick(10'd0, 16'd0, 3'b000, 16'sd0, 32'd0));
    send_tick(make_tick(10'd1023, 16'hFFFF, 3'b111, 16'sd32767, 32'hFFFF_FFFF));
    send_tick(make_tick(10'd0, 16'd0, 3'b001, -16'sd32768, 32'd1));
    send_tick(make_tick(10'd100, 16'd300, 3'b000, 16'sd7680, 32'd2));
    send_tick(make_tick(10'd100, 16'd300, 3'b000, 16'sd7681, 32'd3));
    send_tick(make_tick(10'd512, 16'd5000, 3'b010, 16'sd0, 32'd0));
    send_tick(make_tick(10'd512, 16'd5000, 3'b100, -16'sd1, 32'h8000_0000));
  endtask

  // The current limit is compared with the current before derating.
  task automatic test_derate_limits();
    tick_t  probe;
    longint probe_cur;
    probe = make_tick(10'd700, 16'd9000, 3'b101, 16'sd0, 32'd10);
    probe_cur = load_current(probe);
    wait_drained();
    program_regs(16'sd32767, 19'(probe_cur), 16'd4800, 16'd2400);
    send_tick(probe);
    wait_drained();
    program_regs(16'sd32767, 19'(probe_cur - 1), 16'd4800, 16'd2400);
    send_tick(probe);
    wait_drained();
    program_regs(-16'sd32768, 19'h7FFFF, 16'd4800, 16'd2400);
    send_tick(make_tick(10'd1023, 16'hFFFF, 3'b111, -16'sd32768, 32'd11));
    send_tick(make_tick(10'd1023, 16'hFFFF, 3'b111, -16'sd32767, 32'd12));
    wait_drained();
    program_regs(16'sd32767, 19'd0, 16'd4800, 16'd2400);
    send_tick(make_tick(10'd0, 16'd0, 3'b000, 16'sd32767, 32'd13));
  endtask

  // Zero runtime factor floors the estimate; a large factor at light load caps it.
  task automatic test_runtime_clamps();
    wait_drained();
    program_regs(16'sd7680, 19'd43520, 16'd4800, 16'd0);
    send_tick(make_tick(10'd0, 16'd0, 3'b000, 16'sd0, 32'd20));
    wait_drained();
    program_regs(16'sd7680, 19'd43520, 16'd4800, 16'hFFFF);
    send_tick(make_tick(10'd0, 16'd0, 3'b000, 16'sd0, 32'd21));
  endtask

  task automatic test_random_traffic(int tx_pct, int rx_pct, logic [15:0] divisor);
    wait_drained();
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    program_regs(16'($urandom), 19'($urandom), divisor, 16'($urandom_range(1, 65535)));
    repeat (RandomTicks) send_tick(random_tick());
  endtask

  // The receiver stops for a long stretch while ticks keep coming, so the
  // output register fills and the input has to stall.
  task automatic test_output_stall();
    wait_drained();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    stall_len = StallCycles;
    stall_toggle = ~stall_toggle;
    repeat (6) send_tick(random_tick());
  endtask

  // Run last: once the level sits at its floor it never rises again.
  task automatic test_level_floor();
    wait_drained();
    program_regs(16'sd7680, 19'd43520, 16'd0, 16'd2400);
    send_tick(make_tick(10'd1023, 16'hFFFF, 3'b111, 16'sd0, 32'd30));
    send_tick(make_tick(10'd10, 16'd10, 3'b000, 16'sd0, 32'd31));
    wait_drained();
    program_regs(16'sd7680, 19'd43520, 16'd1, 16'hFFFF);
    send_tick(make_tick(10'd0, 16'd0, 3'b000, 16'sd0, 32'd0));
    send_tick(make_tick(10'd1023, 16'hFFFF, 3'b111, 16'sd100, 32'd33));
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle_pct = 34;
    rx_idle_pct = 53;
    test_reset_values();
    test_derate_limits();
    test_runtime_clamps();
    test_random_traffic(34, 53, 16'($urandom_range(20000, 65534)));
    test_random_traffic(53, 34, 16'($urandom_range(20000, 65534)));
    test_random_traffic(0, 0, 16'hFFFF);
    test_output_stall();
    test_level_floor();
    wait_drained();
    repeat (60) @(posedge clk_i);
    $display("Checked %0d reports for %0d ticks across %0d register settings.",
             reports_seen, ticks_sent, settings_written);
    $display("Covered derate edges, runtime and level clamps, a long output stall, three idle mixes.");
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d reports still expected", mismatches, pending_reports.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/bde_pkg.sv
hdl/battery_drain_estimator.sv
tb/sv/battery_drain_estimator_tb.sv
